/* rtl/sm83_lsu_pkg.sv */
// Shared types and codes for the SM83 load/store unit.
// Holds operation, bus access and register select codes; no dependencies.
package sm83_lsu_pkg;

  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 80;
  localparam int unsigned OutTuserW = 3;

  typedef enum logic [4:0] {
    OP_NOP       = 5'd0,
    OP_LD_R_R    = 5'd1,
    OP_LD_R_N    = 5'd2,
    OP_LD_R_HL   = 5'd3,
    OP_ST_HL_R   = 5'd4,
    OP_ST_HL_N   = 5'd5,
    OP_LD_A_BC   = 5'd6,
    OP_LD_A_DE   = 5'd7,
    OP_LD_A_NN   = 5'd8,
    OP_ST_BC_A   = 5'd9,
    OP_ST_DE_A   = 5'd10,
    OP_ST_NN_A   = 5'd11,
    OP_LDH_A_N   = 5'd12,
    OP_STH_N_A   = 5'd13,
    OP_LDH_A_C   = 5'd14,
    OP_STH_C_A   = 5'd15,
    OP_ST_HLI_A  = 5'd16,
    OP_LD_A_HLI  = 5'd17,
    OP_ST_HLD_A  = 5'd18,
    OP_LD_A_HLD  = 5'd19,
    OP_LD_RR_NN  = 5'd20,
    OP_ST_NN_SP  = 5'd21,
    OP_LD_SP_HL  = 5'd22,
    OP_PUSH      = 5'd23,
    OP_POP       = 5'd24
  } action_e;

  typedef enum logic [2:0] {
    BUS_NONE       = 3'd0,
    BUS_BYTE_READ  = 3'd1,
    BUS_WORD_READ  = 3'd2,
    BUS_BYTE_WRITE = 3'd3,
    BUS_WORD_WRITE = 3'd4
  } bus_kind_e;

  // Register selects: bytes 0..7, pairs 8..11, SP 12
  localparam logic [3:0] TGT_A  = 4'd0;
  localparam logic [3:0] TGT_C  = 4'd3;
  localparam logic [3:0] TGT_H  = 4'd6;
  localparam logic [3:0] TGT_L  = 4'd7;
  localparam logic [3:0] TGT_AF = 4'd8;
  localparam logic [3:0] TGT_BC = 4'd9;
  localparam logic [3:0] TGT_DE = 4'd10;
  localparam logic [3:0] TGT_HL = 4'd11;
  localparam logic [3:0] TGT_SP = 4'd12;

  localparam logic [7:0] HIGH_PAGE = 8'hff;

  localparam logic [4:0] CYC_4  = 5'd4;
  localparam logic [4:0] CYC_8  = 5'd8;
  localparam logic [4:0] CYC_12 = 5'd12;
  localparam logic [4:0] CYC_16 = 5'd16;
  localparam logic [4:0] CYC_20 = 5'd20;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] immediate;
    logic [2:0]  source;
    logic [3:0]  target;
    logic [4:0]  action;
  } req_t;

endpackage

/* rtl/sm83_load_store_unit.sv */
// Load group execute unit of an SM83 style CPU with its own register file.
// Depends on sm83_lsu_pkg for operation codes, bus kinds and the request layout.
//
// Channel  | Dir | Handshake          | Content
// s_axis   | in  | tvalid/tready      | tdata: action, target, source, immediate, read_data
// m_axis   | out | tvalid/tready      | tdata: access fields and register view; tuser: bus kind
//
// One request per cycle while the output is not stalled; results pass the request register,
// then the result register. Store SP gives two results, one per byte write, and holds off
// new requests until its second is loaded. Registers A..L and SP clear on reset.
// A stalled output holds its result and back-pressures through the request register.
module sm83_load_store_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [4:0] action, [8:5] target, [11:9] source, [27:12] immediate, [43:28] read_data
  input  logic [sm83_lsu_pkg::InTdataW-1:0]     s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [15:0] bus_address, [31:16] write_data, [36:32] cycle_count, [44:37] acc_after,
  // [60:45] hl_after, [76:61] sp_after
  output logic [sm83_lsu_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  // [2:0] bus_kind
  output logic [sm83_lsu_pkg::OutTuserW-1:0]    m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);
  import sm83_lsu_pkg::*;

  // Request register
  logic        req_valid_q;
  logic        phase_q;
  req_t        req_q;

  // Register file
  logic [7:0]  regs_q [8];
  logic [7:0]  regs_d [8];
  logic [15:0] sp_q, sp_d;

  // Result register
  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [15:0] out_addr_q, out_wdata_q, out_hl_q, out_sp_q;
  logic [4:0]  out_cyc_q;
  logic [7:0]  out_acc_q;
  logic        out_last_q;

  logic        in_acc, out_ld, final_beat;
  logic [2:0]  kind;
  logic [15:0] addr, wdata;
  logic [4:0]  cyc;

  function automatic logic [15:0] read_sel(input logic [3:0] t);
    logic [15:0] v;
    v = '0;
    if (t < TGT_AF) begin
      v = {8'h00, regs_q[t[2:0]]};
    end else if (t < TGT_SP) begin
      v = {regs_q[{t[1:0], 1'b0}], regs_q[{t[1:0], 1'b1}]};
    end else if (t == TGT_SP) begin
      v = sp_q;
    end
    return v;
  endfunction

  assign final_beat = !((req_q.action == OP_ST_NN_SP) && !phase_q);
  assign out_ld     = req_valid_q && (!out_valid_q || m_axis_tready_i);
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !req_valid_q || (out_ld && final_beat);

  always_comb begin
    logic [15:0] hl, sel_val, tgt_val, hl_val, sp_val;
    logic [7:0]  acc, rb, acc_val;
    logic        tgt_we, acc_we, hl_we, sp_we;
    hl      = {regs_q[TGT_H[2:0]], regs_q[TGT_L[2:0]]};
    acc     = regs_q[TGT_A[2:0]];
    rb      = req_q.read_data[7:0];
    sel_val = read_sel(req_q.target);
    tgt_we  = 1'b0;
    tgt_val = '0;
    acc_we  = 1'b0;
    acc_val = rb;
    hl_we   = 1'b0;
    hl_val  = hl;
    sp_we   = 1'b0;
    sp_val  = sp_q;
    kind    = BUS_NONE;
    addr    = '0;
    wdata   = '0;
    cyc     = CYC_4;

    unique case (req_q.action)
      OP_LD_R_R: begin
        tgt_we = 1'b1; tgt_val = {8'h00, regs_q[req_q.source]};
      end
      OP_LD_R_N: begin
        tgt_we = 1'b1; tgt_val = {8'h00, req_q.immediate[7:0]}; cyc = CYC_8;
      end
      OP_LD_R_HL: begin
        kind = BUS_BYTE_READ; addr = hl; tgt_we = 1'b1; tgt_val = {8'h00, rb}; cyc = CYC_8;
      end
      OP_ST_HL_R: begin
        kind = BUS_BYTE_WRITE; addr = hl; wdata = {8'h00, sel_val[7:0]}; cyc = CYC_8;
      end
      OP_ST_HL_N: begin
        kind = BUS_BYTE_WRITE; addr = hl; wdata = {8'h00, req_q.immediate[7:0]};
        cyc = CYC_12;
      end
      OP_LD_A_BC: begin
        kind = BUS_BYTE_READ; addr = read_sel(TGT_BC); acc_we = 1'b1; cyc = CYC_8;
      end
      OP_LD_A_DE: begin
        kind = BUS_BYTE_READ; addr = read_sel(TGT_DE); acc_we = 1'b1; cyc = CYC_8;
      end
      OP_LD_A_NN: begin
        kind = BUS_BYTE_READ; addr = req_q.immediate; acc_we = 1'b1; cyc = CYC_16;
      end
      OP_ST_BC_A: begin
        kind = BUS_BYTE_WRITE; addr = read_sel(TGT_BC); wdata = {8'h00, acc}; cyc = CYC_8;
      end
      OP_ST_DE_A: begin
        kind = BUS_BYTE_WRITE; addr = read_sel(TGT_DE); wdata = {8'h00, acc}; cyc = CYC_8;
      end
      OP_ST_NN_A: begin
        kind = BUS_BYTE_WRITE; addr = req_q.immediate; wdata = {8'h00, acc}; cyc = CYC_16;
      end
      OP_LDH_A_N: begin
        kind = BUS_BYTE_READ; addr = {HIGH_PAGE, req_q.immediate[7:0]}; acc_we = 1'b1;
        cyc = CYC_12;
      end
      OP_STH_N_A: begin
        kind = BUS_BYTE_WRITE; addr = {HIGH_PAGE, req_q.immediate[7:0]};
        wdata = {8'h00, acc}; cyc = CYC_12;
      end
      OP_LDH_A_C: begin
        kind = BUS_BYTE_READ; addr = {HIGH_PAGE, regs_q[TGT_C[2:0]]}; acc_we = 1'b1;
        cyc = CYC_8;
      end
      OP_STH_C_A: begin
        kind = BUS_BYTE_WRITE; addr = {HIGH_PAGE, regs_q[TGT_C[2:0]]};
        wdata = {8'h00, acc}; cyc = CYC_8;
      end
      OP_ST_HLI_A: begin
        kind = BUS_BYTE_WRITE; addr = hl; wdata = {8'h00, acc};
        hl_we = 1'b1; hl_val = hl + 16'd1; cyc = CYC_8;
      end
      OP_LD_A_HLI: begin
        kind = BUS_BYTE_READ; addr = hl; acc_we = 1'b1;
        hl_we = 1'b1; hl_val = hl + 16'd1; cyc = CYC_8;
      end
      OP_ST_HLD_A: begin
        kind = BUS_BYTE_WRITE; addr = hl; wdata = {8'h00, acc};
        hl_we = 1'b1; hl_val = hl - 16'd1; cyc = CYC_8;
      end
      OP_LD_A_HLD: begin
        kind = BUS_BYTE_READ; addr = hl; acc_we = 1'b1;
        hl_we = 1'b1; hl_val = hl - 16'd1; cyc = CYC_8;
      end
      OP_LD_RR_NN: begin
        tgt_we = 1'b1; tgt_val = req_q.immediate; cyc = CYC_12;
      end
      OP_ST_NN_SP: begin
        // low byte first, high byte at the next address
        kind = BUS_BYTE_WRITE; cyc = CYC_20;
        addr  = phase_q ? req_q.immediate + 16'd1 : req_q.immediate;
        wdata = {8'h00, phase_q ? sp_q[15:8] : sp_q[7:0]};
      end
      OP_LD_SP_HL: begin
        sp_we = 1'b1; sp_val = hl; cyc = CYC_8;
      end
      OP_PUSH: begin
        sp_we = 1'b1; sp_val = sp_q - 16'd2;
        kind = BUS_WORD_WRITE; addr = sp_q - 16'd2; wdata = sel_val; cyc = CYC_16;
      end
      OP_POP: begin
        kind = BUS_WORD_READ; addr = sp_q; cyc = CYC_12;
        tgt_we = 1'b1; tgt_val = req_q.read_data;
        // pop into SP lands first, then the pointer still advances by two
        sp_we  = 1'b1;
        sp_val = ((req_q.target == TGT_SP) ? req_q.read_data : sp_q) + 16'd2;
      end
      default: ;
    endcase

    regs_d = regs_q;
    sp_d   = sp_q;
    if (tgt_we) begin
      if (req_q.target < TGT_AF) begin
        regs_d[req_q.target[2:0]] = tgt_val[7:0];
      end else if (req_q.target < TGT_SP) begin
        regs_d[{req_q.target[1:0], 1'b0}] = tgt_val[15:8];
        regs_d[{req_q.target[1:0], 1'b1}] = tgt_val[7:0];
      end else if (req_q.target == TGT_SP) begin
        sp_d = tgt_val;
      end
    end
    if (acc_we) begin
      regs_d[TGT_A[2:0]] = acc_val;
    end
    if (hl_we) begin
      regs_d[TGT_H[2:0]] = hl_val[15:8];
      regs_d[TGT_L[2:0]] = hl_val[7:0];
    end
    if (sp_we) begin
      sp_d = sp_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (in_acc) begin
      req_valid_q <= 1'b1;
      phase_q     <= 1'b0;
    end else if (out_ld && final_beat) begin
      req_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (out_ld) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_t'(s_axis_tdata_i[$bits(req_t)-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= '0;
      end
      sp_q <= '0;
    end else if (out_ld) begin
      regs_q <= regs_d;
      sp_q   <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_kind_q  <= kind;
      out_addr_q  <= addr;
      out_wdata_q <= wdata;
      out_cyc_q   <= cyc;
      out_acc_q   <= regs_d[TGT_A[2:0]];
      out_hl_q    <= {regs_d[TGT_H[2:0]], regs_d[TGT_L[2:0]]};
      out_sp_q    <= sp_d;
      out_last_q  <= final_beat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'b000, out_sp_q, out_hl_q, out_acc_q, out_cyc_q,
                            out_wdata_q, out_addr_q};

`ifndef SYNTH
  // Only the first byte of store SP is a non-final beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |->
      (m_axis_tuser_o == BUS_BYTE_WRITE && out_cyc_q == CYC_20))
    else $error("non-final result is not a store SP byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (req_valid_q && req_q.action == OP_ST_NN_SP))
    else $error("second beat pending without a store SP request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == BUS_NONE) |->
      (out_addr_q == 16'h0000 && out_wdata_q == 16'h0000))
    else $error("access fields set on a result without bus access");

  // Input stalls only behind a held result or the first byte of store SP
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (req_valid_q && (out_valid_q || !final_beat)))
    else $error("request side stalled while a stage is free");

  // Register file only changes when a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ld |=> ($stable(sp_q) && $stable(regs_q[0])))
    else $error("register state changed without a result");
`endif

endmodule

/* sim/sm83_lsu_checker.sv */
// Scoreboard for the SM83 load/store unit: tracks the register file, predicts bus accesses.
// Watches both stream channels of the unit; depends on sm83_lsu_pkg for codes and layout.
module sm83_lsu_checker
  import sm83_lsu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [InTdataW-1:0]  s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [OutTdataW-1:0] m_tdata_i,
  input  logic [OutTuserW-1:0] m_tuser_i,
  input  logic                 m_tlast_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [4:0]  cycles;
    logic [7:0]  acc;
    logic [15:0] hl;
    logic [15:0] sp;
    logic        last;
  } access_t;

  logic [7:0]  regs [8];
  logic [15:0] stack_ptr;
  access_t     expected_accesses [$];
  int          mismatches = 0;

  function automatic logic [15:0] read_reg(input logic [3:0] sel);
    int unsigned hi;
    hi = 2 * (sel - TGT_AF);
    if (sel < TGT_AF) return {8'h00, regs[sel[2:0]]};
    if (sel < TGT_SP) return {regs[hi], regs[hi+1]};
    if (sel == TGT_SP) return stack_ptr;
    return 16'h0000;
  endfunction

  // Selects past SP are dropped
  task automatic write_reg(input logic [3:0] sel, input logic [15:0] value);
    int unsigned hi;
    hi = 2 * (sel - TGT_AF);
    if (sel < TGT_AF) begin
      regs[sel[2:0]] = value[7:0];
    end else if (sel < TGT_SP) begin
      regs[hi]   = value[15:8];
      regs[hi+1] = value[7:0];
    end else if (sel == TGT_SP) begin
      stack_ptr = value;
    end
  endtask

  task automatic log_access(input bus_kind_e kind, input logic [15:0] addr,
                            input logic [15:0] wdata, input logic [4:0] cycles,
                            input logic last);
    access_t acc;
    acc.kind   = kind;
    acc.addr   = addr;
    acc.wdata  = wdata;
    acc.cycles = cycles;
    acc.acc    = regs[TGT_A[2:0]];
    acc.hl     = read_reg(TGT_HL);
    acc.sp     = stack_ptr;
    acc.last   = last;
    expected_accesses.push_back(acc);
  endtask

  task automatic execute_load(input req_t req);
    logic [15:0] hl_now;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic [15:0] pushed;
    logic [7:0]  acc_now;
    logic [7:0]  rd_byte;
    logic [4:0]  cycles;
    bus_kind_e   kind;
    hl_now  = read_reg(TGT_HL);
    acc_now = regs[TGT_A[2:0]];
    rd_byte = req.read_data[7:0];
    kind    = BUS_NONE;
    addr    = 16'h0000;
    wdata   = 16'h0000;
    cycles  = CYC_4;
    if (req.action == OP_ST_NN_SP) begin
      // Two byte writes, low byte first; address wraps
      log_access(BUS_BYTE_WRITE, req.immediate, {8'h00, stack_ptr[7:0]}, CYC_20, 1'b0);
      log_access(BUS_BYTE_WRITE, req.immediate + 16'd1, {8'h00, stack_ptr[15:8]}, CYC_20,
                 1'b1);
    end else begin
      case (req.action)
        OP_LD_R_R: write_reg(req.target, {8'h00, regs[req.source]});
        OP_LD_R_N: begin
          write_reg(req.target, {8'h00, req.immediate[7:0]});
          cycles = CYC_8;
        end
        OP_LD_R_HL: begin
          kind = BUS_BYTE_READ; addr = hl_now; cycles = CYC_8;
          write_reg(req.target, {8'h00, rd_byte});
        end
        OP_ST_HL_R: begin
          kind = BUS_BYTE_WRITE; addr = hl_now; cycles = CYC_8;
          wdata = read_reg(req.target) & 16'h00ff;
        end
        OP_ST_HL_N: begin
          kind = BUS_BYTE_WRITE; addr = hl_now; cycles = CYC_12;
          wdata = {8'h00, req.immediate[7:0]};
        end
        OP_LD_A_BC, OP_LD_A_DE: begin
          kind = BUS_BYTE_READ; cycles = CYC_8;
          addr = read_reg(req.action == OP_LD_A_BC ? TGT_BC : TGT_DE);
          write_reg(TGT_A, {8'h00, rd_byte});
        end
        OP_LD_A_NN: begin
          kind = BUS_BYTE_READ; addr = req.immediate; cycles = CYC_16;
          write_reg(TGT_A, {8'h00, rd_byte});
        end
        OP_ST_BC_A, OP_ST_DE_A: begin
          kind = BUS_BYTE_WRITE; cycles = CYC_8; wdata = {8'h00, acc_now};
          addr = read_reg(req.action == OP_ST_BC_A ? TGT_BC : TGT_DE);
        end
        OP_ST_NN_A: begin
          kind = BUS_BYTE_WRITE; addr = req.immediate; cycles = CYC_16;
          wdata = {8'h00, acc_now};
        end
        OP_LDH_A_N: begin
          kind = BUS_BYTE_READ; addr = {HIGH_PAGE, req.immediate[7:0]}; cycles = CYC_12;
          write_reg(TGT_A, {8'h00, rd_byte});
        end
        OP_STH_N_A: begin
          kind = BUS_BYTE_WRITE; addr = {HIGH_PAGE, req.immediate[7:0]}; cycles = CYC_12;
          wdata = {8'h00, acc_now};
        end
        OP_LDH_A_C: begin
          kind = BUS_BYTE_READ; addr = {HIGH_PAGE, regs[TGT_C[2:0]]}; cycles = CYC_8;
          write_reg(TGT_A, {8'h00, rd_byte});
        end
        OP_STH_C_A: begin
          kind = BUS_BYTE_WRITE; addr = {HIGH_PAGE, regs[TGT_C[2:0]]}; cycles = CYC_8;
          wdata = {8'h00, acc_now};
        end
        OP_ST_HLI_A, OP_ST_HLD_A: begin
          kind = BUS_BYTE_WRITE; addr = hl_now; cycles = CYC_8; wdata = {8'h00, acc_now};
          write_reg(TGT_HL, req.action == OP_ST_HLI_A ? hl_now + 16'd1 : hl_now - 16'd1);
        end
        OP_LD_A_HLI, OP_LD_A_HLD: begin
          kind = BUS_BYTE_READ; addr = hl_now; cycles = CYC_8;
          write_reg(TGT_A, {8'h00, rd_byte});
          write_reg(TGT_HL, req.action == OP_LD_A_HLI ? hl_now + 16'd1 : hl_now - 16'd1);
        end
        OP_LD_RR_NN: begin
          write_reg(req.target, req.immediate);
          cycles = CYC_12;
        end
        OP_LD_SP_HL: begin
          stack_ptr = hl_now;
          cycles = CYC_8;
        end
        OP_PUSH: begin
          // Read the pair before SP moves
          pushed = read_reg(req.target);
          stack_ptr = stack_ptr - 16'd2;
          kind = BUS_WORD_WRITE; addr = stack_ptr; wdata = pushed; cycles = CYC_16;
        end
        OP_POP: begin
          kind = BUS_WORD_READ; addr = stack_ptr; cycles = CYC_12;
          write_reg(req.target, req.read_data);
          stack_ptr = stack_ptr + 16'd2;
        end
        default: ;
      endcase
      log_access(kind, addr, wdata, cycles, 1'b1);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s mismatch: expected %h, got %h", $realtime,
                                     what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs[i] = 8'h00;
      stack_ptr = 16'h0000;
      expected_accesses.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) execute_load(req_t'(s_tdata_i[$bits(req_t)-1:0]));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_accesses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result: tdata %h tuser %h",
                                         $realtime, m_tdata_i, m_tuser_i);
        end else begin
          want = expected_accesses.pop_front();
          check_field("bus_kind", 16'(want.kind), 16'(m_tuser_i[2:0]));
          check_field("bus_address", want.addr, m_tdata_i[15:0]);
          check_field("write_data", want.wdata, m_tdata_i[31:16]);
          check_field("cycle_count", 16'(want.cycles), 16'(m_tdata_i[36:32]));
          check_field("acc_after", 16'(want.acc), 16'(m_tdata_i[44:37]));
          check_field("hl_after", want.hl, m_tdata_i[60:45]);
          check_field("sp_after", want.sp, m_tdata_i[76:61]);
          check_field("last", 16'(want.last), 16'(m_tlast_i));
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_accesses.size();
  end

endmodule

/* sim/tb_sm83_load_store_unit.sv */
// Testbench top for sm83_load_store_unit: clock, reset, load-group request stimulus.
// Depends on sm83_lsu_pkg, the unit itself and sm83_lsu_checker for prediction.
module tb_sm83_load_store_unit;
  import sm83_lsu_pkg::*;

  localparam logic [4:0] ACTION_UNUSED_LO = 5'd25;
  localparam logic [4:0] ACTION_UNUSED_HI = 5'd31;
  localparam logic [3:0] TGT_F            = 4'd1;
  localparam logic [3:0] TGT_NONE_LO      = 4'd13;
  localparam logic [3:0] TGT_NONE_HI      = 4'd15;
  localparam int         RandomItems      = 1950;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic [OutTuserW-1:0] m_tuser;
  logic                 m_tlast;
  int                   errors;
  int                   pending;

  int unsigned burst_left = 0;
  int unsigned sent       = 0;
  int unsigned phase_left = 0;
  int unsigned mask_bit   = 0;
  logic [15:0] stall_mask = '1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sm83_load_store_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  sm83_lsu_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Receiver: each phase picks a 16-bit ready mask with at least one set bit
  always @(posedge clk_i) begin
    if (phase_left == 0) begin
      phase_left = $urandom_range(40, 300);
      case ($urandom_range(0, 3))
        0:       stall_mask = '1;
        1:       stall_mask = 16'($urandom);
        2:       stall_mask = 16'($urandom & $urandom);
        default: stall_mask = ~16'($urandom & $urandom);
      endcase
      stall_mask[$urandom_range(0, 15)] = 1'b1;
    end
    phase_left--;
    m_tready <= stall_mask[mask_bit];
    mask_bit = (mask_bit + 1) % 16;
  end

  function automatic req_t make_request(input logic [4:0] act, input logic [3:0] tgt,
                                        input logic [2:0] src, input logic [15:0] imm,
                                        input logic [15:0] rd);
    req_t req;
    req.action    = act;
    req.target    = tgt;
    req.source    = src;
    req.immediate = imm;
    req.read_data = rd;
    return req;
  endfunction

  // Favor the wrap points of addresses and bytes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h00ff;
      3:       return 16'hff00;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_target(input logic [3:0] lo, input logic [3:0] hi);
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(TGT_NONE_LO, TGT_NONE_HI));
    return 4'($urandom_range(lo, hi));
  endfunction

  // Sender works in bursts; hold tvalid high across back-to-back requests
  task automatic send(input req_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InTdataW - $bits(req_t)){1'b0}}, req};
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  initial begin
    #2000000;
    $display("tb_sm83_load_store_unit: errors");
    $finish;
  end

  initial begin
    logic [4:0] act;
    int unsigned steps;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: wraps, pair and unknown selects, every operation
    send(make_request(OP_LD_RR_NN, TGT_HL, 3'd0, 16'hffff, 16'h0000));
    send(make_request(OP_LD_R_N, TGT_A, 3'd0, 16'h12ff, 16'hffff));
    send(make_request(OP_ST_HLI_A, TGT_A, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_LD_A_HLD, TGT_A, 3'd0, 16'h0000, 16'hab5a));
    send(make_request(OP_LD_RR_NN, TGT_SP, 3'd0, 16'h0001, 16'h0000));
    send(make_request(OP_PUSH, TGT_AF, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_POP, TGT_SP, 3'd0, 16'h0000, 16'hfffe));
    send(make_request(OP_ST_NN_SP, TGT_A, 3'd0, 16'hffff, 16'h0000));
    send(make_request(OP_LD_R_N, TGT_BC, 3'd0, 16'habcd, 16'h0000));
    send(make_request(OP_LD_R_R, TGT_NONE_LO, 3'd7, 16'h0000, 16'h0000));
    send(make_request(OP_PUSH, TGT_NONE_HI, 3'd0, 16'h0000, 16'h0000));
    send(make_request(ACTION_UNUSED_LO, TGT_A, 3'd0, 16'hffff, 16'hffff));
    send(make_request(ACTION_UNUSED_HI, TGT_NONE_HI, 3'd7, 16'hffff, 16'hffff));
    send(make_request(OP_ST_HL_R, TGT_SP, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_LD_R_HL, TGT_F, 3'd0, 16'h0000, 16'hffff));
    send(make_request(OP_LD_R_R, TGT_C, 3'd1, 16'h0000, 16'h0000));
    send(make_request(OP_ST_HL_N, TGT_A, 3'd0, 16'h00ff, 16'h0000));
    send(make_request(OP_LDH_A_N, TGT_A, 3'd0, 16'h00ff, 16'h8001));
    send(make_request(OP_STH_N_A, TGT_A, 3'd0, 16'hff00, 16'h0000));
    send(make_request(OP_LDH_A_C, TGT_A, 3'd0, 16'h0000, 16'h007e));
    send(make_request(OP_STH_C_A, TGT_A, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_LD_A_BC, TGT_A, 3'd0, 16'h0000, 16'h0042));
    send(make_request(OP_ST_DE_A, TGT_A, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_LD_A_DE, TGT_A, 3'd0, 16'h0000, 16'h00c3));
    send(make_request(OP_ST_BC_A, TGT_A, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_LD_A_NN, TGT_A, 3'd0, 16'h0000, 16'h0099));
    send(make_request(OP_ST_NN_A, TGT_A, 3'd0, 16'hffff, 16'h0000));
    send(make_request(OP_LD_SP_HL, TGT_A, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_LD_A_HLI, TGT_A, 3'd0, 16'h0000, 16'h0011));
    send(make_request(OP_ST_HLD_A, TGT_A, 3'd0, 16'h0000, 16'h0000));
    send(make_request(OP_NOP, TGT_A, 3'd0, 16'h0000, 16'h0000));

    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // Stack run: set SP, favoring wrap points, then pushes, pops and SP stores
          send(make_request(OP_LD_RR_NN, TGT_SP, 3'($urandom), pick_word(), pick_word()));
          steps = $urandom_range(2, 8);
          repeat (steps) begin
            case ($urandom_range(0, 4))
              0, 1:    act = OP_PUSH;
              2, 3:    act = OP_POP;
              default: act = OP_ST_NN_SP;
            endcase
            send(make_request(act, pick_target(TGT_AF, TGT_SP), 3'($urandom), pick_word(),
                              pick_word()));
          end
        end
        2, 3: begin
          // HL walk, favoring the address wrap
          send(make_request(OP_LD_RR_NN, TGT_HL, 3'($urandom), pick_word(), pick_word()));
          steps = $urandom_range(2, 8);
          repeat (steps) begin
            act = 5'($urandom_range(OP_ST_HLI_A, OP_LD_A_HLD));
            send(make_request(act, 4'($urandom), 3'($urandom), pick_word(), pick_word()));
          end
        end
        default: begin
          act = ($urandom_range(0, 9) == 0) ?
                5'($urandom_range(ACTION_UNUSED_LO, ACTION_UNUSED_HI)) :
                5'($urandom_range(OP_NOP, OP_POP));
          send(make_request(act, pick_target(TGT_A, TGT_SP), 3'($urandom), pick_word(),
                            pick_word()));
        end
      endcase
    end
    s_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_sm83_load_store_unit: clean");
    end else begin
      $display("tb_sm83_load_store_unit: errors");
    end
    $finish;
  end

endmodule
